// ===== src/min_coin_change_dp_defines.svh =====
// ----------------------------------------------------------------------------
// min_coin_change_dp_defines.svh
// Assertion macros for the minimum coin change block.
// ----------------------------------------------------------------------------
`ifndef MIN_COIN_CHANGE_DP_DEFINES_SVH
`define MIN_COIN_CHANGE_DP_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define MCCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define MCCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MCCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/mccd_pkg.sv =====
// ----------------------------------------------------------------------------
// mccd_pkg
// Shared constants and types for the minimum coin change block.
// ----------------------------------------------------------------------------
package mccd_pkg;

    // highest amount held in the count table
    localparam int unsigned MAX_AMOUNT = 1023;
    localparam int unsigned TBL_DEPTH  = MAX_AMOUNT + 1;
    localparam int unsigned ADDR_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // fixed field widths
    localparam int unsigned AMT_W = 10;
    localparam int unsigned CNT_W = 11;

    typedef logic [AMT_W-1:0]  t_amount;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [ADDR_W-1:0] t_addr;

    // all ones marks an amount that cannot be formed
    localparam t_count UNREACH = {CNT_W{1'b1}};

endpackage

// ===== src/mccd_if.sv =====
// ----------------------------------------------------------------------------
// mccd_if
// Valid/ready channels for coin transactions and result transactions.
// ----------------------------------------------------------------------------
interface mccd_coin_if;
    logic                valid;
    logic                ready;
    mccd_pkg::t_amount   coin_value;
    logic                last_coin;

    modport source (output valid, output coin_value, output last_coin, input ready);
    modport sink   (input valid, input coin_value, input last_coin, output ready);
endinterface

interface mccd_result_if;
    logic                valid;
    logic                ready;
    mccd_pkg::t_amount   min_coins;
    logic                formable;

    modport source (output valid, output min_coins, output formable, input ready);
    modport sink   (input valid, input min_coins, input formable, output ready);
endinterface

// ===== src/mccd_ram.sv =====
// ----------------------------------------------------------------------------
// mccd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read-first: a same-cycle write is not visible
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/mccd_relax.sv =====
// ----------------------------------------------------------------------------
// mccd_relax
// Add-one and compare unit: best = min(cur, sub + 1), unreachable aware.
// ----------------------------------------------------------------------------
module mccd_relax (
    input  mccd_pkg::t_count i_sub,
    input  mccd_pkg::t_count i_cur,
    output mccd_pkg::t_count o_best
);

    mccd_pkg::t_count w_cand;

    // the increment wraps only for an all-ones sub, which the compare excludes
    assign w_cand = i_sub + mccd_pkg::CNT_W'(1);

    always_comb begin
        o_best = i_cur;
        if ((i_sub != mccd_pkg::UNREACH) && (w_cand != mccd_pkg::UNREACH)
                && (w_cand < i_cur)) begin
            o_best = w_cand;
        end
    end

endmodule

// ===== src/min_coin_change_dp.sv =====
// ----------------------------------------------------------------------------
// min_coin_change_dp
// Fewest coins forming a target amount, one denomination per transaction.
// ----------------------------------------------------------------------------
// Each coin transaction sweeps the count table (one entry per amount
// 0..MAX_AMOUNT) from the coin value upward, one entry per cycle, through a
// single add-compare unit: best[j] = min(best[j], best[j-coin] + 1). A coin
// of value c updates entries c..MAX_AMOUNT, the read data registered before
// each write-back; a zero coin, or one above MAX_AMOUNT, updates none.
// The pace is set by the table RAM: one write port, one entry updated per
// cycle. A coin flagged last additionally reads the entry for the target,
// loads the result register (a result transaction comes out only for the
// last coin) and then runs a clearing pass over every entry that
// rewrites the table to entry 0 = 0 and all others unreachable. The same
// clearing pass runs after reset, so the first coin is taken only once
// that pass is done. No coin is taken during a sweep or a clearing pass. A
// finished result waits in its own register while the next set's coins are
// swept; only the next set's result load (and so its clearing pass) waits
// until that earlier result has been taken. The user must write the target
// register (i_cfg_wr_en / i_cfg_wr_data) only while idle; the block does not
// enforce it. Only the value held at the target read and result load matters.
// ----------------------------------------------------------------------------
`include "min_coin_change_dp_defines.svh"

module min_coin_change_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  mccd_pkg::t_amount  i_cfg_wr_data,
    mccd_coin_if.sink          i_coin,
    mccd_result_if.source      o_result
);

    // sequencer states
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,  // table rewrite, one entry per cycle
        S_IDLE  = 6'b000010,  // waiting for a coin transaction
        S_SWEEP = 6'b000100,  // issuing table reads for the current coin
        S_DRAIN = 6'b001000,  // last update of the sweep writes back
        S_TREAD = 6'b010000,  // target entry read issued
        S_TRES  = 6'b100000   // target entry available, load result
    } t_state;

    t_state              r_state, n_state;
    mccd_pkg::t_addr     r_j, n_j;          // sweep / clear index
    mccd_pkg::t_addr     r_coin;            // current denomination
    logic                r_last;
    logic                r_pv;              // read data in flight
    mccd_pkg::t_addr     r_pj;              // entry the in-flight data belongs to
    mccd_pkg::t_count    r_prev;            // last value written this sweep
    logic                r_prev_ok;
    mccd_pkg::t_amount   r_target;
    logic                r_tgt_ok;
    logic                r_out_valid;
    mccd_pkg::t_amount   r_out_cnt;
    logic                r_out_ok;

    logic                w_coin_acc;
    logic                w_coin_skip;
    logic                w_j_end;
    logic                w_out_free;
    logic                w_we;
    mccd_pkg::t_addr     w_waddr;
    mccd_pkg::t_count    w_wdata;
    mccd_pkg::t_addr     w_raddr_a;
    mccd_pkg::t_count    w_rdata_a;
    mccd_pkg::t_count    w_rdata_b;
    mccd_pkg::t_count    w_sub;
    mccd_pkg::t_count    w_best;

    // ---------------------------------------------------------------- handshake
    assign i_coin.ready  = (r_state == S_IDLE);
    assign w_coin_acc    = i_coin.valid && i_coin.ready;
    // zero coin or one beyond the table leaves every entry as it is
    assign w_coin_skip   = (i_coin.coin_value == '0)
                        || (32'(i_coin.coin_value) > mccd_pkg::MAX_AMOUNT);
    assign w_j_end       = (r_j == mccd_pkg::ADDR_W'(mccd_pkg::MAX_AMOUNT));
    assign w_out_free    = !r_out_valid || o_result.ready;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        unique case (r_state)
            S_CLEAR: begin
                n_j = r_j + mccd_pkg::ADDR_W'(1);
                if (w_j_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_coin_acc) begin
                    n_j = mccd_pkg::ADDR_W'(i_coin.coin_value);
                    if (!w_coin_skip) begin
                        n_state = S_SWEEP;
                    end else if (i_coin.last_coin) begin
                        n_state = S_TREAD;
                    end
                end
            end
            S_SWEEP: begin
                n_j = r_j + mccd_pkg::ADDR_W'(1);
                if (w_j_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_last ? S_TREAD : S_IDLE;
            end
            S_TREAD: begin
                n_state = S_TRES;
            end
            S_TRES: begin
                if (w_out_free) begin
                    n_state = S_CLEAR;
                    n_j     = '0;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_j     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_j       <= '0;
            r_pv      <= 1'b0;
            r_prev_ok <= 1'b0;
            r_target  <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_pv    <= (r_state == S_SWEEP);
            if (w_coin_acc) begin
                r_prev_ok <= 1'b0;
            end else if (r_pv) begin
                r_prev_ok <= 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
        end
    end

    // payload of the sweep pipeline
    always_ff @(posedge i_clk) begin
        if (w_coin_acc) begin
            r_coin <= mccd_pkg::ADDR_W'(i_coin.coin_value);
            r_last <= i_coin.last_coin;
        end
        r_pj <= r_j;
        if (r_pv) begin
            r_prev <= w_best;
        end
        if (r_state == S_TREAD) begin
            r_tgt_ok <= (32'(r_target) <= mccd_pkg::MAX_AMOUNT);
        end
    end

    // ---------------------------------------------------------------- table
    // Port a reads best[j-coin], port b reads best[j]. Port a is held on the
    // target entry while the result is picked up.
    assign w_raddr_a = ((r_state == S_TREAD) || (r_state == S_TRES))
                     ? mccd_pkg::ADDR_W'(r_target) : (r_j - r_coin);

    // A coin of one reads the entry written in the same cycle; RAM is
    // read-first, so take the freshly written value instead.
    assign w_sub = ((r_coin == mccd_pkg::ADDR_W'(1)) && r_prev_ok) ? r_prev : w_rdata_a;

    mccd_relax u_relax (
        .i_sub  (w_sub),
        .i_cur  (w_rdata_b),
        .o_best (w_best)
    );

    assign w_we    = (r_state == S_CLEAR) || r_pv;
    assign w_waddr = (r_state == S_CLEAR) ? r_j : r_pj;
    assign w_wdata = (r_state == S_CLEAR)
                   ? ((r_j == '0) ? '0 : mccd_pkg::UNREACH) : w_best;

    mccd_ram #(
        .WIDTH (mccd_pkg::CNT_W),
        .DEPTH (mccd_pkg::TBL_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (r_j),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // ---------------------------------------------------------------- result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_TRES) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_TRES) && w_out_free) begin
            if (r_tgt_ok && (w_rdata_a != mccd_pkg::UNREACH)) begin
                r_out_cnt <= w_rdata_a[mccd_pkg::AMT_W-1:0];
                r_out_ok  <= 1'b1;
            end else begin
                r_out_cnt <= '0;
                r_out_ok  <= 1'b0;
            end
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.min_coins = r_out_cnt;
    assign o_result.formable  = r_out_ok;

    // ---------------------------------------------------------------- checks
    `MCCD_ASSERT_SAME(a_pipe_range, i_clk, i_rst_n, r_pv, (r_pj >= r_coin) && (r_coin != '0), "sweep update below coin value")
    `MCCD_ASSERT_NEXT(a_clear_done, i_clk, i_rst_n, (r_state == S_CLEAR) && w_j_end, r_state == S_IDLE, "clearing pass did not end in idle")
    `MCCD_ASSERT_SAME(a_result_src, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_TRES, "result loaded outside result state")
    `MCCD_ASSERT_SAME(a_unformable, i_clk, i_rst_n, o_result.valid && !o_result.formable, o_result.min_coins == '0, "nonzero count on unformable result")

endmodule
